// ----- rtl/rvx_pkg.sv -----
// rvx_pkg: shared types and constants for the rv32 subset executor
// no dependencies; imported by rvx_front, rvx_back and rv32_subset_executor

package rvx_pkg;

  // register file geometry (x0 reads as zero)
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);

  // queue between front and back, and result queue
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = OUT_AW + 1;

  // request types
  localparam logic [2:0] REQ_EXEC = 3'd0;
  localparam logic [2:0] REQ_WREG = 3'd1;
  localparam logic [2:0] REQ_WMEM = 3'd2;
  localparam logic [2:0] REQ_RREG = 3'd3;
  localparam logic [2:0] REQ_RMEM = 3'd4;

  // opcodes of the subset
  localparam logic [6:0] OPC_RTYPE = 7'd51;
  localparam logic [6:0] OPC_ADDI  = 7'd19;
  localparam logic [6:0] OPC_LOAD  = 7'd3;
  localparam logic [6:0] OPC_STORE = 7'd35;

  // operation kinds after decode
  localparam logic [2:0] KIND_NOP   = 3'd0;
  localparam logic [2:0] KIND_ALU   = 3'd1;
  localparam logic [2:0] KIND_LOAD  = 3'd2;
  localparam logic [2:0] KIND_STORE = 3'd3;
  localparam logic [2:0] KIND_WREG  = 3'd4;
  localparam logic [2:0] KIND_WMEM  = 3'd5;
  localparam logic [2:0] KIND_RREG  = 3'd6;
  localparam logic [2:0] KIND_RMEM  = 3'd7;

  // decoded operation
  typedef struct packed {
    logic [2:0]        kind;
    logic              sub;
    logic              use_imm;
    logic              unknown;
    logic              rs1_used;
    logic              rs2_used;
    logic              rd_we;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rs2;
    logic [REG_AW-1:0] rd;
    logic [31:0]       data;
    logic [9:0]        tgt;
  } uop_t;

  // one result word
  typedef struct packed {
    logic [31:0] read_value;
    logic        unknown_opcode;
  } res_t;

endpackage

// ----- rtl/rvx_ram.sv -----
// rvx_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/rvx_front.sv -----
// rvx_front: accepts request words, decodes them and queues decoded operations
// depends on rvx_pkg

module rvx_front
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [31:0] instr_word,
  input  logic [9:0]  target_index,
  input  logic [31:0] write_value,
  input  logic        head_pop,
  output logic        head_valid,
  output uop_t        head
);

  uop_t              uop_d;
  uop_t              q_r [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr_r;
  logic [MID_AW-1:0] rd_ptr_r;
  logic [MID_AW:0]   cnt_r;
  logic [MID_AW:0]   cnt_nxt;
  logic              do_push;
  logic              do_pop;
  logic [31:0]       imm_i;
  logic [31:0]       imm_s;

  assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
  assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};

  always_comb begin
    uop_d = '0;
    unique case (req_type)
      REQ_EXEC: begin
        uop_d.rs1 = instr_word[19:15];
        uop_d.rs2 = instr_word[24:20];
        uop_d.rd  = instr_word[11:7];
        unique case (instr_word[6:0])
          OPC_RTYPE: begin
            uop_d.kind     = KIND_ALU;
            uop_d.sub      = |instr_word[31:25];
            uop_d.rs1_used = 1'b1;
            uop_d.rs2_used = 1'b1;
            uop_d.rd_we    = |instr_word[11:7];
          end
          OPC_ADDI: begin
            uop_d.kind     = KIND_ALU;
            uop_d.use_imm  = 1'b1;
            uop_d.data     = imm_i;
            uop_d.rs1_used = 1'b1;
            uop_d.rd_we    = |instr_word[11:7];
          end
          OPC_LOAD: begin
            uop_d.kind     = KIND_LOAD;
            uop_d.use_imm  = 1'b1;
            uop_d.data     = imm_i;
            uop_d.rs1_used = 1'b1;
            uop_d.rd_we    = |instr_word[11:7];
          end
          OPC_STORE: begin
            uop_d.kind     = KIND_STORE;
            uop_d.use_imm  = 1'b1;
            uop_d.data     = imm_s;
            uop_d.rs1_used = 1'b1;
            uop_d.rs2_used = 1'b1;
          end
          default: begin
            uop_d.kind    = KIND_NOP;
            uop_d.unknown = 1'b1;
          end
        endcase
      end
      REQ_WREG: begin
        uop_d.kind  = KIND_WREG;
        uop_d.rd    = target_index[REG_AW-1:0];
        uop_d.data  = write_value;
        uop_d.rd_we = |target_index[REG_AW-1:0];
      end
      REQ_WMEM: begin
        uop_d.kind = KIND_WMEM;
        uop_d.data = write_value;
        uop_d.tgt  = target_index;
      end
      REQ_RREG: begin
        uop_d.kind     = KIND_RREG;
        uop_d.rs1      = target_index[REG_AW-1:0];
        uop_d.rs1_used = 1'b1;
      end
      REQ_RMEM: begin
        uop_d.kind = KIND_RMEM;
        uop_d.tgt  = target_index;
      end
      default: begin
        uop_d.kind = KIND_NOP;
      end
    endcase
  end

  assign full       = (cnt_r == (MID_AW + 1)'(MID_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= uop_d;
    end
  end

endmodule

// ----- rtl/rvx_back.sv -----
// rvx_back: issue, execute, memory and writeback stages with register file and data memory
// depends on rvx_pkg and rvx_ram

module rvx_back
  import rvx_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  uop_t              head,
  output logic              head_pop,
  input  logic [OUT_CW-1:0] out_free,
  output logic              res_valid,
  output res_t              res
);

  localparam int MAW   = $clog2(MEM_WORDS);
  localparam int SHIFT = 30 + MAW;
  // exact reciprocal for quotients of 30-bit word indexes
  localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];

  typedef struct packed {
    logic [2:0]        kind;
    logic              rd_we;
    logic              unknown;
    logic [REG_AW-1:0] rd;
    logic [31:0]       val;
  } stg_t;

  // stage registers
  logic              e_v_r, m_v_r, w_v_r;
  uop_t              e_r;
  stg_t              m_r, w_r;
  logic [29:0]       m_x_r;
  logic [61:0]       m_prod_r;
  logic              e_a_vld_r, e_b_vld_r;
  logic [REG_COUNT-1:0] rf_vld_r;
  logic              l_v_r;
  logic [REG_AW-1:0] l_rd_r;
  logic [31:0]       l_data_r;

  logic [31:0]       rf_a_q, rf_b_q, mem_q;
  logic              hazard, credit_ok, issue;
  logic              m_fwd, wb_we;
  logic [31:0]       wb_data;
  logic [31:0]       a, b, op2, sum, e_val;
  logic [29:0]       e_x;
  logic [61:0]       e_prod;
  logic [29:0]       m_q;
  logic [61:0]       m_qd;
  logic [MAW-1:0]    m_idx;
  logic              mem_we;

  // issue: hold back a reader of a load still in execute, and keep room in the result queue
  assign hazard = e_v_r && (e_r.kind == KIND_LOAD) && e_r.rd_we &&
                  ((head.rs1_used && (head.rs1 == e_r.rd)) ||
                   (head.rs2_used && (head.rs2 == e_r.rd)));
  assign credit_ok = out_free > (OUT_CW'(e_v_r) + OUT_CW'(m_v_r) + OUT_CW'(w_v_r));
  assign issue     = head_valid && !hazard && credit_ok;
  assign head_pop  = issue;

  rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(wb_we), .waddr(w_r.rd), .wdata(wb_data),
    .raddr(head.rs1), .rdata(rf_a_q)
  );

  rvx_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(wb_we), .waddr(w_r.rd), .wdata(wb_data),
    .raddr(head.rs2), .rdata(rf_b_q)
  );

  // execute: operands with bypass, newest first
  assign m_fwd = m_v_r && m_r.rd_we && (m_r.kind != KIND_LOAD);

  always_comb begin
    a = e_a_vld_r ? rf_a_q : '0;
    if (l_v_r && (l_rd_r == e_r.rs1)) begin
      a = l_data_r;
    end
    if (wb_we && (w_r.rd == e_r.rs1)) begin
      a = wb_data;
    end
    if (m_fwd && (m_r.rd == e_r.rs1)) begin
      a = m_r.val;
    end
    b = e_b_vld_r ? rf_b_q : '0;
    if (l_v_r && (l_rd_r == e_r.rs2)) begin
      b = l_data_r;
    end
    if (wb_we && (w_r.rd == e_r.rs2)) begin
      b = wb_data;
    end
    if (m_fwd && (m_r.rd == e_r.rs2)) begin
      b = m_r.val;
    end
  end

  assign op2 = e_r.use_imm ? e_r.data : b;
  assign sum = e_r.sub ? (a - op2) : (a + op2);

  always_comb begin
    case (e_r.kind)
      KIND_ALU:              e_val = sum;
      KIND_WREG, KIND_WMEM:  e_val = e_r.data;
      KIND_RREG:             e_val = a;
      KIND_STORE:            e_val = b;
      default:               e_val = '0;
    endcase
  end

  assign e_x    = ((e_r.kind == KIND_LOAD) || (e_r.kind == KIND_STORE)) ? sum[31:2]
                                                                        : 30'(e_r.tgt);
  assign e_prod = 62'(e_x) * 62'(RECIP);

  // memory: index modulo depth by reciprocal quotient
  assign m_q    = 30'(m_prod_r >> SHIFT);
  assign m_qd   = 62'(m_q) * 62'(MEM_WORDS);
  assign m_idx  = MAW'(62'(m_x_r) - m_qd);
  assign mem_we = m_v_r && ((m_r.kind == KIND_STORE) || (m_r.kind == KIND_WMEM));

  rvx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(mem_we), .waddr(m_idx), .wdata(m_r.val),
    .raddr(m_idx), .rdata(mem_q)
  );

  // writeback
  assign wb_we   = w_v_r && w_r.rd_we;
  assign wb_data = (w_r.kind == KIND_LOAD) ? mem_q : w_r.val;

  assign res_valid = w_v_r;
  always_comb begin
    res = '0;
    res.unknown_opcode = w_r.unknown;
    if (w_r.kind == KIND_RREG) begin
      res.read_value = w_r.val;
    end else if (w_r.kind == KIND_RMEM) begin
      res.read_value = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r    <= 1'b0;
      m_v_r    <= 1'b0;
      w_v_r    <= 1'b0;
      l_v_r    <= 1'b0;
      rf_vld_r <= '0;
    end else begin
      e_v_r <= issue;
      m_v_r <= e_v_r;
      w_v_r <= m_v_r;
      l_v_r <= wb_we;
      if (wb_we) begin
        rf_vld_r[w_r.rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= head;
    e_a_vld_r  <= rf_vld_r[head.rs1];
    e_b_vld_r  <= rf_vld_r[head.rs2];
    m_r.kind    <= e_r.kind;
    m_r.rd_we   <= e_r.rd_we;
    m_r.unknown <= e_r.unknown;
    m_r.rd      <= e_r.rd;
    m_r.val     <= e_val;
    m_x_r      <= e_x;
    m_prod_r   <= e_prod;
    w_r        <= m_r;
    l_rd_r     <= w_r.rd;
    l_data_r   <= wb_data;
  end

endmodule

// ----- rtl/rv32_subset_executor.sv -----
// rv32_subset_executor: top level, front decode, back pipeline and result queue
// depends on rvx_pkg, rvx_front, rvx_back and rvx_ram
//
// usage
//   input channel: present in_req_type, in_instr_word, in_target_index and
//   in_write_value with push; the word is taken at a clock edge with push high
//   and full low. result channel: while empty is low the oldest result word is
//   on out_read_value and out_unknown_opcode; it is taken with pop high.
//   every input word gives exactly one result word, in order.
// timing
//   a taken word passes execute, memory and writeback into the result queue.
//   one word per cycle while the result queue has room; a word reading a
//   register loaded by the word just before it is held while that load is in
//   execute, as the loaded data leaves the data memory read port in writeback.
// reset
//   synchronous, active low: both queues empty, the register file reads zero
//   (a valid flag per register); data memory is undefined until written.
// stalls
//   results wait in an eight-word queue; the back end issues only while every
//   word in flight has a free slot there, and the four-word queue behind the
//   decoder then fills and raises full.

module rv32_subset_executor
  import rvx_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_instr_word,
  input  logic [9:0]  in_target_index,
  input  logic [31:0] in_write_value,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_read_value,
  output logic        out_unknown_opcode
);

  // front to back
  uop_t              head;
  logic              head_valid;
  logic              head_pop;

  // back to result queue
  logic              res_valid;
  res_t              res;

  // result queue
  res_t              oq_r [OUT_DEPTH];
  logic [OUT_AW-1:0] owr_ptr_r;
  logic [OUT_AW-1:0] ord_ptr_r;
  logic [OUT_CW-1:0] ocnt_r;
  logic [OUT_CW-1:0] ocnt_nxt;
  logic [OUT_CW-1:0] out_free;
  logic              do_pop;
  res_t              ohead;

  rvx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .req_type     (in_req_type),
    .instr_word   (in_instr_word),
    .target_index (in_target_index),
    .write_value  (in_write_value),
    .head_pop     (head_pop),
    .head_valid   (head_valid),
    .head         (head)
  );

  rvx_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue: never overflows, the back end reserves a slot per word in flight
  assign empty    = (ocnt_r == '0);
  assign do_pop   = pop && !empty;
  assign out_free = OUT_CW'(OUT_DEPTH) - ocnt_r;
  assign ohead    = oq_r[ord_ptr_r];

  assign out_read_value     = ohead.read_value;
  assign out_unknown_opcode = ohead.unknown_opcode;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_valid && !do_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (do_pop && !res_valid) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (res_valid) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oq_r[owr_ptr_r] <= res;
    end
  end

  // checks

  // a finished word always finds a free slot in the result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (ocnt_r < OUT_CW'(OUT_DEPTH)))
    else $error("result queue overflow");

  // a finished word shows on the result side at the next edge
  a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !empty)
    else $error("finished word not visible");

  // both sides come out of reset empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // nothing is issued to the back end while the result queue has no reserve
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == OUT_CW'(OUT_DEPTH)) |-> !head_pop)
    else $error("issue with full result queue");

endmodule
